>>> rtl/double_ended_queue_macros.svh
// Assertion macros for the double-ended queue RTL.
// Included by files that carry concurrent checks; depends on clk and rst_n in scope.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

`ifndef SYNTHESIS

// check a condition at every clock edge outside reset
`define DEQ_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("deque check failed");

// check that a condition holds in the cycle after a trigger
`define DEQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deque check failed");

`else

`define DEQ_ASSERT_ALWAYS(lbl, cond)
`define DEQ_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> rtl/deq_pkg.sv
// Shared types and constants for the double-ended queue.
// No dependencies; used by deq_cell and double_ended_queue.
package deq_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int WORD_W       = 64;
  localparam int COUNT_W      = 7;

  typedef enum logic [1:0] {
    MODE_PUSH_TAIL = 2'd0,
    MODE_POP_TAIL  = 2'd1,
    MODE_PUSH_HEAD = 2'd2,
    MODE_POP_HEAD  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    mode_t              mode;
    logic [WORD_W-1:0]  data_in;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0]  data_out;
    status_t            status;
    logic [COUNT_W-1:0] count;
  } out_item_t;

  // work for the whole cell row: row moves and the word
  typedef struct packed {
    logic              push_tail;
    logic              pop_tail;
    logic              push_head;
    logic              pop_head;
    logic [WORD_W-1:0] word;
  } cell_ctl_t;

endpackage

>>> rtl/deq_cell.sv
// One storage cell of the deque row: a valid bit and an entry word.
// Depends on deq_pkg; neighbors are wired by double_ended_queue.
module deq_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  deq_pkg::cell_ctl_t        ctl,
  input  logic                      left_valid,
  input  logic [deq_pkg::WORD_W-1:0] left_data,
  input  logic                      right_valid,
  input  logic [deq_pkg::WORD_W-1:0] right_data,
  output logic                      valid,
  output logic [deq_pkg::WORD_W-1:0] data,
  output logic                      is_last
);
  import deq_pkg::*;

  logic              valid_r, valid_nxt;
  logic [WORD_W-1:0] data_r, data_nxt;
  logic              tail_slot;

  // first empty cell behind the last valid one takes a tail push
  assign tail_slot = !valid_r && left_valid;
  assign is_last   = valid_r && !right_valid;

  // head push shifts tailward, head pop headward, else tail push or pop
  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (ctl.push_head) begin
      valid_nxt = left_valid;
      data_nxt  = left_data;
    end else if (ctl.pop_head) begin
      valid_nxt = right_valid;
      data_nxt  = right_data;
    end else if (ctl.push_tail && tail_slot) begin
      valid_nxt = 1'b1;
      data_nxt  = ctl.word;
    end else if (ctl.pop_tail && is_last) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid = valid_r;
  assign data  = data_r;

endmodule

>>> rtl/double_ended_queue.sv
// Double-ended queue built as a row of CAPACITY cells, head at cell 0.
// A result is registered in the cycle after its request is accepted.
// Throughput: one request per cycle while the result side takes transfers;
// every request moves the cell row by at most one place.
// Reset: clears the cell valid bits, the entry count and the result valid flag;
// entry words and the result payload keep their contents.
module double_ended_queue #(
  parameter int CAPACITY = deq_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  deq_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output deq_pkg::out_item_t out_item
);
  import deq_pkg::*;

  `include "double_ended_queue_macros.svh"

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic              in_acc;
  logic              empty, full, is_push;
  cell_ctl_t         ctl;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;
  logic [WORD_W-1:0] tail_word;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;

  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY-1:0] cell_last;
  logic [WORD_W-1:0]   cell_data [CAPACITY];

  // hold the input while a finished result waits
  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CAP_CNT);
  assign is_push = (in_item.mode == MODE_PUSH_TAIL) || (in_item.mode == MODE_PUSH_HEAD);

  // decode the request into row moves
  always_comb begin
    ctl.push_tail = in_acc && !full  && (in_item.mode == MODE_PUSH_TAIL);
    ctl.pop_tail  = in_acc && !empty && (in_item.mode == MODE_POP_TAIL);
    ctl.push_head = in_acc && !full  && (in_item.mode == MODE_PUSH_HEAD);
    ctl.pop_head  = in_acc && !empty && (in_item.mode == MODE_POP_HEAD);
    ctl.word      = in_item.data_in;
  end

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic              lv, rv;
    logic [WORD_W-1:0] ld, rd;
    if (i == 0) begin : g_first
      assign lv = 1'b1;
      assign ld = in_item.data_in;
    end else begin : g_mid_l
      assign lv = cell_valid[i-1];
      assign ld = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign rv = 1'b0;
      assign rd = '0;
    end else begin : g_mid_r
      assign rv = cell_valid[i+1];
      assign rd = cell_data[i+1];
    end
    deq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .left_valid  (lv),
      .left_data   (ld),
      .right_valid (rv),
      .right_data  (rd),
      .valid       (cell_valid[i]),
      .data        (cell_data[i]),
      .is_last     (cell_last[i])
    );
  end

  // pick the tail entry: one cell is last whenever the deque is not empty
  always_comb begin
    tail_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tail_word = tail_word | (cell_data[i] & {WORD_W{cell_last[i]}});
    end
  end

  // advance the entry count
  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.push_tail || ctl.push_head) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (ctl.pop_tail || ctl.pop_head) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  assign cnt_ext = {{COUNT_W{1'b0}}, cnt_nxt};

  // build the result and load the output register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    if (in_acc) begin
      out_valid_nxt         = 1'b1;
      out_item_nxt.data_out = '0;
      out_item_nxt.status   = ST_OK;
      out_item_nxt.count    = cnt_ext[COUNT_W-1:0];
      if (is_push) begin
        if (full) begin
          out_item_nxt.status = ST_FULL;
        end
      end else if (empty) begin
        out_item_nxt.status = ST_EMPTY;
      end else if (in_item.mode == MODE_POP_TAIL) begin
        out_item_nxt.data_out = tail_word;
      end else begin
        out_item_nxt.data_out = cell_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // checks
  `DEQ_ASSERT_ALWAYS(a_count_matches_cells, cnt_r == CNT_W'($countones(cell_valid)))
  `DEQ_ASSERT_ALWAYS(a_cells_packed, $onehot0(cell_last) && ((cnt_r == '0) || $onehot(cell_last)))
  `DEQ_ASSERT_NEXT(a_empty_pop, in_acc && !is_push && empty, out_item_r.status == ST_EMPTY)
  `DEQ_ASSERT_NEXT(a_full_push, in_acc && is_push && full, out_item_r.status == ST_FULL)

endmodule
